### rtl/olid_pkg.sv
package olid_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int WORD_W   = 32;

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_INSERT_AT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_POP_FRONT  = 3'd4,
		OP_DELETE_AT  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic                     ins;
		logic                     del;
		logic [CNT_W-1:0]         pos;
		logic signed [WORD_W-1:0] value;
	} cell_cmd_t;

endpackage

### rtl/olid_req_if.sv
interface olid_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic [3:0]         position;
	logic signed [31:0] value;

	modport source (output valid, operation, position, value, input ready);
	modport sink   (input valid, operation, position, value, output ready);
endinterface

### rtl/olid_rsp_if.sv
interface olid_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [4:0]         entry_count;
	logic signed [31:0] first_value;
	logic signed [31:0] last_value;

	modport source (output valid, status, entry_count, first_value, last_value, input ready);
	modport sink   (input valid, status, entry_count, first_value, last_value, output ready);
endinterface

### rtl/olid_cell.sv
module olid_cell import olid_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  cell_cmd_t                cmd,
	input  logic signed [WORD_W-1:0] below,
	input  logic signed [WORD_W-1:0] above,
	output logic signed [WORD_W-1:0] entry_q,
	output logic signed [WORD_W-1:0] entry_d
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	// Insert: load at the position, take from below above it.
	// Delete: take from above at and past the position.
	always_comb begin
		entry_d = entry_q;
		if (cmd.ins) begin
			if (MY_IDX == cmd.pos) begin
				entry_d = cmd.value;
			end else if (MY_IDX > cmd.pos) begin
				entry_d = below;
			end
		end else if (cmd.del) begin
			if (MY_IDX >= cmd.pos) begin
				entry_d = above;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

### rtl/olid_ctrl.sv
module olid_ctrl import olid_pkg::*; (
	input  logic                     accept,
	input  logic [2:0]               operation,
	input  logic [3:0]               position,
	input  logic signed [WORD_W-1:0] value,
	input  logic [CNT_W-1:0]         count_q,
	output cell_cmd_t                cmd,
	output status_t                  status,
	output logic [CNT_W-1:0]         count_d
);

	logic [CNT_W-1:0] pos_ext;
	logic [CNT_W-1:0] cell_pos;
	logic             full;
	logic             empty;
	logic             ins_ok;
	logic             del_ok;

	assign pos_ext = CNT_W'(position);
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign empty   = (count_q == '0);

	// Operation decode: status and the effective cell position
	always_comb begin
		status   = ST_OK;
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		cell_pos = '0;
		unique case (op_t'(operation))
			OP_PUSH_BACK: begin
				cell_pos = count_q;
				if (full) status = ST_FULL;
				else ins_ok = 1'b1;
			end
			OP_PUSH_FRONT: begin
				if (full) status = ST_FULL;
				else ins_ok = 1'b1;
			end
			OP_INSERT_AT: begin
				cell_pos = pos_ext;
				if (pos_ext >= count_q) status = ST_BADPOS;
				else if (full) status = ST_FULL;
				else ins_ok = 1'b1;
			end
			OP_POP_BACK: begin
				cell_pos = count_q - CNT_W'(1);
				if (empty) status = ST_EMPTY;
				else del_ok = 1'b1;
			end
			OP_POP_FRONT: begin
				if (empty) status = ST_EMPTY;
				else del_ok = 1'b1;
			end
			OP_DELETE_AT: begin
				cell_pos = pos_ext;
				if (empty) status = ST_EMPTY;
				else if (pos_ext >= count_q) status = ST_BADPOS;
				else del_ok = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign cmd.ins   = accept && ins_ok;
	assign cmd.del   = accept && del_ok;
	assign cmd.pos   = cell_pos;
	assign cmd.value = value;

	// Count after the request
	always_comb begin
		count_d = count_q;
		if (ins_ok) count_d = count_q + CNT_W'(1);
		else if (del_ok) count_d = count_q - CNT_W'(1);
	end

endmodule

### rtl/ordered_list_insert_delete.sv
// Bounded ordered list of signed 32-bit words, up to 16 entries.
// Channel req (sink) carries one request: operation, position, value.
// Channel rsp (source) returns one response per request: status, the
// entry count after the request, and the first and last entries (zero when
// the list is empty).
// The entries sit in a chain of cells; on an insert every cell above the
// position takes its lower neighbor, on a delete every cell at or above the
// position takes its upper neighbor, all in the same cycle.
// The response is valid the cycle after the request is accepted.
// Throughput: one request per cycle while rsp.ready is high; the single response register sets it.
// req.ready stays high while the response register is empty or being
// drained, so a new request is taken in the same cycle the previous
// response is taken. When rsp.ready is low with a response held, req.ready
// drops and the list holds still.
// Reset clears the entry count and the response valid; cell contents are
// left as they are, since only entries below the count are ever read.
module ordered_list_insert_delete import olid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	olid_req_if.sink   req,
	olid_rsp_if.source rsp
);

	logic                     accept;
	cell_cmd_t                cmd;
	status_t                  status_d;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic [CNT_W-1:0]         last_idx;
	logic signed [WORD_W-1:0] cell_q [CAPACITY];
	logic signed [WORD_W-1:0] cell_d [CAPACITY];
	logic                     rsp_valid_q;
	status_t                  status_q;
	logic [CNT_W-1:0]         rsp_count_q;
	logic signed [WORD_W-1:0] first_q;
	logic signed [WORD_W-1:0] last_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	olid_ctrl u_ctrl (
		.accept    (accept),
		.operation (req.operation),
		.position  (req.position),
		.value     (req.value),
		.count_q   (count_q),
		.cmd       (cmd),
		.status    (status_d),
		.count_d   (count_d)
	);

	// Cell chain; the ends see themselves as the missing neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		olid_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.below   ((i == 0) ? cell_q[i] : cell_q[(i == 0) ? 0 : i - 1]),
			.above   ((i == CAPACITY - 1) ? cell_q[i]
			          : cell_q[(i == CAPACITY - 1) ? i : i + 1]),
			.entry_q (cell_q[i]),
			.entry_d (cell_d[i])
		);
	end

	assign last_idx = count_d - CNT_W'(1);

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			rsp_count_q <= count_d;
			if (count_d == '0) begin
				first_q <= '0;
				last_q  <= '0;
			end else begin
				first_q <= cell_d[0];
				last_q  <= cell_d[last_idx[IDX_W-1:0]];
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.first_value = first_q;
	assign rsp.last_value  = last_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the count");

	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("delete did not shrink the count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_count_q == '0 |-> first_q == '0 && last_q == '0)
		else $error("empty list response not zero");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == ST_FULL |-> rsp_count_q == CNT_W'(CAPACITY))
		else $error("full status with room left");

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import olid_pkg::*;

	// Codes outside the defined set: the list must not change
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int IDLE_PERCENT    = 31;
	localparam int MAX_PRINTED     = 30;
	localparam int RANDOM_ITEMS    = 900;
	localparam int BACK_TO_BACK    = 200;

	// What one response should show after a request
	typedef struct {
		status_t            status;
		logic [4:0]         entry_count;
		logic signed [31:0] first_value;
		logic signed [31:0] last_value;
	} list_view_t;

	logic clk;
	logic arst_n;

	olid_req_if req_if ();
	olid_rsp_if rsp_if ();

	ordered_list_insert_delete dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Shadow copy of the list
	logic signed [31:0] shadow_cells [CAPACITY];
	int                 shadow_count;

	list_view_t expected_views [$];
	int         mismatch_count;
	int         response_index;
	int         cycle_count;
	bit         idle_enabled;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** ordered_list_insert_delete: FAILED **");
			$finish;
		end
	end

	// Apply one request to the shadow list and queue the view it leaves
	function automatic void apply_list_op(input logic [2:0] op, input logic [3:0] pos,
			input logic signed [31:0] val);
		status_t    st;
		bit         ins;
		bit         del;
		int         at;
		int         i;
		list_view_t view;
		st  = ST_OK;
		ins = 1'b0;
		del = 1'b0;
		at  = 0;
		case (op)
			OP_PUSH_BACK: begin
				ins = 1'b1;
				at  = shadow_count;
			end
			OP_PUSH_FRONT: begin
				ins = 1'b1;
			end
			OP_INSERT_AT: begin
				if (int'(pos) >= shadow_count) begin
					st = ST_BADPOS;
				end else begin
					ins = 1'b1;
					at  = int'(pos);
				end
			end
			OP_POP_BACK: begin
				del = 1'b1;
				at  = shadow_count - 1;
			end
			OP_POP_FRONT: begin
				del = 1'b1;
			end
			OP_DELETE_AT: begin
				del = 1'b1;
				at  = int'(pos);
			end
			default: ;
		endcase
		if (ins) begin
			if (shadow_count >= CAPACITY) begin
				st = ST_FULL;
			end else begin
				for (i = shadow_count; i > at; i--)
					shadow_cells[i] = shadow_cells[i-1];
				shadow_cells[at] = val;
				shadow_count++;
			end
		end
		if (del) begin
			if (shadow_count == 0) begin
				st = ST_EMPTY;
			end else if (at >= shadow_count) begin
				st = ST_BADPOS;
			end else begin
				for (i = at + 1; i < shadow_count; i++)
					shadow_cells[i-1] = shadow_cells[i];
				shadow_count--;
			end
		end
		view.status      = st;
		view.entry_count = shadow_count[4:0];
		view.first_value = (shadow_count == 0) ? 32'sd0 : shadow_cells[0];
		view.last_value  = (shadow_count == 0) ? 32'sd0 : shadow_cells[shadow_count-1];
		expected_views.push_back(view);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("mismatch on response %0d: %s got %h expected %h",
				response_index, what, got, want);
	endtask

	// Send one request, with a random gap ahead of it
	task automatic send_request(input logic [2:0] op, input logic [3:0] pos,
			input logic signed [31:0] val);
		while (idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
			req_if.valid <= 1'b0;
			req_if.value <= $urandom;
			@(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.operation <= op;
		req_if.position  <= pos;
		req_if.value     <= val;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		apply_list_op(op, pos, val);
	endtask

	// Response side: random stalls
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_if.ready <= idle_enabled ? ($urandom_range(0, 99) >= IDLE_PERCENT) : 1'b1;
		end
	end

	// Compare each response with the oldest expected view
	always @(posedge clk) begin
		list_view_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_views.size() == 0) begin
				report_mismatch("unexpected response, status", 32'(rsp_if.status), 32'd0);
			end else begin
				want = expected_views.pop_front();
				if (rsp_if.status !== want.status)
					report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
				if (rsp_if.entry_count !== want.entry_count)
					report_mismatch("entry_count", 32'(rsp_if.entry_count),
						32'(want.entry_count));
				if (rsp_if.first_value !== want.first_value)
					report_mismatch("first_value", rsp_if.first_value, want.first_value);
				if (rsp_if.last_value !== want.last_value)
					report_mismatch("last_value", rsp_if.last_value, want.last_value);
			end
			response_index++;
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly a position inside the list, now and then anything
	function automatic logic [3:0] pick_position();
		if (shadow_count > 0 && $urandom_range(0, 99) < 80)
			return 4'($urandom_range(0, shadow_count - 1));
		return 4'($urandom_range(0, 15));
	endfunction

	// insert_weight: percent of the defined-code requests that are insert operations
	function automatic logic [2:0] pick_op(input int insert_weight);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
		if ($urandom_range(0, 99) < insert_weight) begin
			case ($urandom_range(0, 2))
				0: return OP_PUSH_BACK;
				1: return OP_PUSH_FRONT;
				default: return OP_INSERT_AT;
			endcase
		end
		case ($urandom_range(0, 2))
			0: return OP_POP_BACK;
			1: return OP_POP_FRONT;
			default: return OP_DELETE_AT;
		endcase
	endfunction

	// Removals, a position insert and a spare code on an empty list
	task automatic test_empty_list();
		send_request(OP_POP_BACK, 4'd0, 32'sd0);
		send_request(OP_POP_FRONT, 4'd0, 32'sd0);
		send_request(OP_DELETE_AT, 4'd15, 32'sd0);
		send_request(OP_INSERT_AT, 4'd0, 32'sd5);
		send_request(OP_SPARE_6, 4'd0, 32'sd9);
	endtask

	// Fill to capacity, refusals when full, bad delete position
	task automatic test_fill_and_limits();
		int k;
		send_request(OP_PUSH_BACK, 4'd0, 32'sh7fffffff);
		send_request(OP_PUSH_FRONT, 4'd15, 32'sh80000000);
		send_request(OP_INSERT_AT, 4'd0, -32'sd1);
		send_request(OP_INSERT_AT, 4'd2, 32'sd0);
		for (k = 0; k < CAPACITY - 4; k++) begin
			case (k % 3)
				0: send_request(OP_PUSH_BACK, 4'($urandom), $urandom);
				1: send_request(OP_PUSH_FRONT, 4'($urandom), $urandom);
				default: send_request(OP_INSERT_AT, 4'($urandom_range(0, shadow_count - 1)),
					$urandom);
			endcase
		end
		send_request(OP_PUSH_BACK, 4'd0, 32'sd1);
		send_request(OP_PUSH_FRONT, 4'd0, 32'sd2);
		send_request(OP_INSERT_AT, 4'd15, 32'sd3);
		send_request(OP_SPARE_7, 4'd3, 32'sd4);
		send_request(OP_DELETE_AT, 4'd15, 32'sd0);
		send_request(OP_DELETE_AT, 4'd15, 32'sd0);
	endtask

	// Bursts that fill, drain or churn the list
	task automatic test_random_bursts(input int items);
		int sent;
		int burst_len;
		int weight;
		int n;
		logic [2:0] op;
		sent = 0;
		while (sent < items) begin
			burst_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: weight = 75;
				1: weight = 25;
				default: weight = 50;
			endcase
			for (n = 0; n < burst_len && sent < items; n++) begin
				op = pick_op(weight);
				send_request(op, pick_position(), pick_value());
				sent++;
			end
		end
	endtask

	// Requests and responses with no idle cycles on either side
	task automatic test_back_to_back();
		idle_enabled = 1'b0;
		test_random_bursts(BACK_TO_BACK);
		idle_enabled = 1'b1;
	endtask

	initial begin
		mismatch_count = 0;
		response_index = 0;
		shadow_count   = 0;
		idle_enabled   = 1'b1;
		arst_n         = 1'b0;
		req_if.valid     <= 1'b0;
		req_if.operation <= OP_PUSH_BACK;
		req_if.position  <= 4'd0;
		req_if.value     <= 32'sd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_fill_and_limits();
		test_random_bursts(RANDOM_ITEMS / 2);
		test_back_to_back();
		test_random_bursts(RANDOM_ITEMS / 2);

		req_if.valid <= 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_views.size() == 0)
			$display("** ordered_list_insert_delete: PASSED **");
		else
			$display("** ordered_list_insert_delete: FAILED **");
		$finish;
	end

endmodule
